FILE: rtl/core/sorted_timer_queue_defines.svh
// ---------------------------------------------------------------------------
// Sorted timer queue: assertion macros
// Immediate-implication and next-cycle-implication property macros.
// ---------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define STQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define STQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STQ_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define STQ_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/core/stq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted timer queue package
// Operation and result codes, controller command and status words.
// ---------------------------------------------------------------------------
package stq_pkg;

  localparam int CTX_BITS = 16;
  localparam int DELAY_BITS = 16;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ACCEPT = 2'd0;
  localparam kind_t KIND_FULL   = 2'd1;
  localparam kind_t KIND_FIRED  = 2'd2;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // Logical index used for the memory read
  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_HEAD
  } rd_sel_t;

  typedef struct packed {
    logic    load_reg;     // latch new expiry / context, idx = 0
    logic    tick_inc;     // advance second counter
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    idx_inc;
    logic    shift_start;  // pos = idx, idx = count
    logic    wr_shift;     // entry[idx] = entry[idx-1], idx--
    logic    wr_new;       // entry[pos] = new, count++
    logic    fire_take;    // hold head context, pop head
    logic    fire_clear;   // drop held flag
    logic    emit;
    kind_t   emit_kind;
    logic    emit_last;
  } stq_cmd_t;

  typedef struct packed {
    logic full;
    logic count_zero;
    logic idx_at_count;
    logic idx_at_pos;
    logic later;       // read entry expires later than new entry
    logic due;         // read entry is due at current second
    logic have_held;
  } stq_status_t;

endpackage

FILE: rtl/core/sorted_timer_queue.sv
// ---------------------------------------------------------------------------
// Sorted timer queue
// Table of one-shot timers kept in expiry order, fired by a one-second tick.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low. operation selects a
// register (delay_secs, context_req) or a one-second tick. A register word
// gives one result word: accepted, or rejected when all TIMER_SLOTS entries
// are pending. A tick advances the wrapping second counter and gives one
// fired word per due timer, in expiry order (equal expiries in registration
// order), with last set on the final one; a tick with nothing due gives no
// word. Results appear for one cycle with strobe high and cannot be held
// off by the receiver. Entries live in a circular single-port-read memory
// with registered read data, so each step of the walk is a read state
// followed by a compare or write state. A rejected register word leaves
// busy low and answers on the next cycle. busy stays high through the
// insert scan and shift of an accepted register word and through the
// expiry walk of a tick; the next word may be taken while the last result
// of the previous one is still on the ports.
// ---------------------------------------------------------------------------
`include "sorted_timer_queue_defines.svh"

module sorted_timer_queue #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation,
  input  logic [stq_pkg::DELAY_BITS-1:0] delay_secs,
  input  logic [stq_pkg::CTX_BITS-1:0]   context_req,
  output logic                           strobe,
  output stq_pkg::kind_t                 result_kind,
  output logic [stq_pkg::CTX_BITS-1:0]   fired_context,
  output logic                           last
);
  import stq_pkg::*;

  stq_cmd_t    cmd;
  stq_status_t st;

  // sequencer: insert scan / shift and expiry walk
  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .st        (st),
    .busy      (busy),
    .cmd       (cmd)
  );

  // entry memory, counters and result register
  stq_dpath #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .TIME_BITS   (TIME_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .delay_secs    (delay_secs),
    .context_req   (context_req),
    .st            (st),
    .strobe        (strobe),
    .result_kind   (result_kind),
    .fired_context (fired_context),
    .last          (last)
  );

  // every taken word either starts a walk or answers at once (full table)
  `STQ_ASSERT_NXT(a_accept_progress, clk, rst, start && !busy,
                  busy || strobe, "taken word dropped")
  // register answers carry no context and end their word
  `STQ_ASSERT_IMP(a_reply_shape, clk, rst, strobe && (result_kind != KIND_FIRED),
                  last && (fired_context == '0), "bad register reply")

endmodule

FILE: rtl/core/stq_ctrl.sv
// ---------------------------------------------------------------------------
// Sorted timer queue controller
// Sequences the sorted insert and the expiry walk over the datapath.
// ---------------------------------------------------------------------------
module stq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                operation,
  input  stq_pkg::stq_status_t st,
  output logic                busy,
  output stq_pkg::stq_cmd_t   cmd
);
  import stq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_FIRE_RD  = 3'd5;
  localparam logic [2:0] S_FIRE_CMP = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_TICK) begin
            cmd.tick_inc = 1'b1;
            state_next   = S_FIRE_RD;
          end else if (st.full) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_FULL;
            cmd.emit_last = 1'b1;
          end else begin
            cmd.load_reg = 1'b1;
            state_next   = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (st.idx_at_count) begin
          cmd.shift_start = 1'b1;
          state_next      = S_SHIFT_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (st.later) begin
          cmd.shift_start = 1'b1;
          state_next      = S_SHIFT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (st.idx_at_pos) begin
          cmd.wr_new    = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_ACCEPT;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_FIRE_RD: begin
        if (st.count_zero) begin
          cmd.emit       = st.have_held;
          cmd.emit_kind  = KIND_FIRED;
          cmd.emit_last  = 1'b1;
          cmd.fire_clear = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_next = S_FIRE_CMP;
        end
      end
      S_FIRE_CMP: begin
        cmd.emit      = st.have_held;
        cmd.emit_kind = KIND_FIRED;
        if (st.due) begin
          // held entry is not the last: another one is due
          cmd.emit_last = 1'b0;
          cmd.fire_take = 1'b1;
          state_next    = S_FIRE_RD;
        end else begin
          cmd.emit_last  = 1'b1;
          cmd.fire_clear = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/stq_dpath.sv
// ---------------------------------------------------------------------------
// Sorted timer queue datapath
// Circular entry memory, second counter, indexes and result register.
// ---------------------------------------------------------------------------
`include "sorted_timer_queue_defines.svh"

module stq_dpath #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  stq_pkg::stq_cmd_t               cmd,
  input  logic [stq_pkg::DELAY_BITS-1:0]  delay_secs,
  input  logic [stq_pkg::CTX_BITS-1:0]    context_req,
  output stq_pkg::stq_status_t            st,
  output logic                            strobe,
  output stq_pkg::kind_t                  result_kind,
  output logic [stq_pkg::CTX_BITS-1:0]    fired_context,
  output logic                            last
);
  import stq_pkg::*;

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int DW = TIME_BITS + CTX_BITS;

  logic [DW-1:0]        mem [TIMER_SLOTS];
  logic [DW-1:0]        rd_data;
  logic [TIME_BITS-1:0] cur;
  logic [CW-1:0]        count;
  logic [IW-1:0]        head;
  logic [IW-1:0]        idx;
  logic [IW-1:0]        pos;
  logic [TIME_BITS-1:0] exp_new;
  logic [CTX_BITS-1:0]  ctx_new;
  logic [CTX_BITS-1:0]  held_ctx;
  logic                 have_held;

  logic [IW-1:0]        rd_log;
  logic [IW-1:0]        wr_log;
  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        wr_addr;
  logic [DW-1:0]        wr_data;
  logic                 wr_en;
  logic [TIME_BITS-1:0] rd_exp;
  logic [TIME_BITS-1:0] diff_later;
  logic [TIME_BITS-1:0] diff_due;

  // logical position -> slot, relative to head
  function automatic logic [IW-1:0] to_phys(input logic [IW-1:0] hd,
                                            input logic [IW-1:0] lg);
    logic [IW:0] sum;
    sum = {1'b0, hd} + {1'b0, lg};
    if (sum >= (IW+1)'(TIMER_SLOTS)) begin
      sum = sum - (IW+1)'(TIMER_SLOTS);
    end
    return sum[IW-1:0];
  endfunction

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    rd_log = idx;
      RD_IDX_M1: rd_log = idx - 1'b1;
      RD_HEAD:   rd_log = '0;
      default:   rd_log = '0;
    endcase
  end

  assign wr_log  = cmd.wr_new ? pos : idx;
  assign rd_addr = to_phys(head, rd_log);
  assign wr_addr = to_phys(head, wr_log);
  assign wr_en   = cmd.wr_new | cmd.wr_shift;
  assign wr_data = cmd.wr_new ? {exp_new, ctx_new} : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // wrapped compares
  assign rd_exp     = rd_data[DW-1:CTX_BITS];
  assign diff_later = rd_exp - exp_new;
  assign diff_due   = cur - rd_exp;

  assign st.full         = (count == CW'(TIMER_SLOTS));
  assign st.count_zero   = (count == '0);
  assign st.idx_at_count = (CW'(idx) == count);
  assign st.idx_at_pos   = (idx == pos);
  assign st.later        = (diff_later != '0) && !diff_later[TIME_BITS-1];
  assign st.due          = !diff_due[TIME_BITS-1];
  assign st.have_held    = have_held;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      count     <= '0;
      head      <= '0;
      have_held <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      if (cmd.tick_inc) begin
        cur <= cur + 1'b1;
      end
      if (cmd.wr_new) begin
        count <= count + 1'b1;
      end else if (cmd.fire_take) begin
        count <= count - 1'b1;
      end
      if (cmd.fire_take) begin
        head      <= (head == IW'(TIMER_SLOTS - 1)) ? '0 : head + 1'b1;
        have_held <= 1'b1;
      end else if (cmd.fire_clear) begin
        have_held <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_reg) begin
      exp_new <= cur + TIME_BITS'(delay_secs);
      ctx_new <= context_req;
      idx     <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end else if (cmd.shift_start) begin
      idx <= count[IW-1:0];
    end else if (cmd.wr_shift) begin
      idx <= idx - 1'b1;
    end
    if (cmd.shift_start) begin
      pos <= idx;
    end
    if (cmd.fire_take) begin
      held_ctx <= rd_data[CTX_BITS-1:0];
    end
    if (cmd.emit) begin
      result_kind   <= cmd.emit_kind;
      fired_context <= (cmd.emit_kind == KIND_FIRED) ? held_ctx : '0;
      last          <= cmd.emit_last;
    end
  end

  `STQ_ASSERT_IMP(a_insert_not_full, clk, rst, cmd.wr_new, count < CW'(TIMER_SLOTS), "insert into full table")
  `STQ_ASSERT_IMP(a_pop_not_empty, clk, rst, cmd.fire_take, count != '0, "pop from empty table")

endmodule
